/* rtl/fppd_pkg.sv */
// Package for the fine-position PD controller: state codes, request codes,
// fixed-point constants and the output saturation function. No dependencies.
package fppd_pkg;

  localparam int unsigned SQRT_STEPS = 33;  // root bits of a 66-bit radicand
  localparam int unsigned DIV_STEPS  = 51;  // quotient bits of the PD numerator

  localparam logic signed [25:0] PI_Q     = 26'sd205887;
  localparam logic signed [25:0] TWO_PI_Q = 26'sd411775;
  localparam logic signed [32:0] KP_LIN   = 33'sd169083;  // 2.58 in Q16
  localparam logic signed [32:0] KD_LIN   = 33'sd47000;   // 0.047 per microsecond
  localparam logic signed [32:0] KD_ANG   = 33'sd100000;  // 0.1 per microsecond

  // request kinds
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_START  = 2'd1;
  localparam logic [1:0] REQ_STOP   = 2'd2;

  // register indexes
  localparam logic [2:0] REG_TGT_DIST = 3'd0;
  localparam logic [2:0] REG_TGT_ANG  = 3'd1;
  localparam logic [2:0] REG_MAX_LIN  = 3'd2;
  localparam logic [2:0] REG_MAX_ANG  = 3'd3;
  localparam logic [2:0] REG_DIST_TOL = 3'd4;
  localparam logic [2:0] REG_ANG_TOL  = 3'd5;

  typedef enum logic [19:0] {
    S_IDLE   = 20'h00001,
    S_SQX    = 20'h00002,
    S_SQX_W  = 20'h00004,
    S_SQY    = 20'h00008,
    S_SQY_W  = 20'h00010,
    S_SUM    = 20'h00020,
    S_ITER   = 20'h00040,
    S_ITDONE = 20'h00080,
    S_ARR    = 20'h00100,
    S_PREP   = 20'h00200,
    S_LP     = 20'h00400,
    S_LP_W   = 20'h00800,
    S_LD     = 20'h01000,
    S_LD_W   = 20'h02000,
    S_LDIV   = 20'h04000,
    S_DIVEND = 20'h08000,
    S_AD     = 20'h10000,
    S_AD_W   = 20'h20000,
    S_ADIV   = 20'h40000,
    S_FIN    = 20'h80000
  } state_t;

  // clip from above at the cap, from below at the 32-bit minimum
  function automatic logic [31:0] sat_cap(input logic signed [52:0] v,
                                          input logic signed [31:0] c);
    logic signed [52:0] cw;
    logic signed [52:0] r;
    cw = 53'(c);
    r  = (v > cw) ? cw : v;
    if (r < -53'sd2147483648) r = -53'sd2147483648;
    return r[31:0];
  endfunction

endpackage

/* rtl/fine_position_pd_controller.sv */
// Sequence: a running odometry word takes two 33-step square roots and two 51-step
// divisions on one shared restoring unit, plus multiply and sequencing states. Arrival
// skips the second root and the divisions, the first sample skips both as well, and a
// later zero time step skips the divisions. A stalled result holds the block; in_tready
// rises again the cycle after the result loads. Start, stop and idle samples are
// handled in the idle state and can follow back to back.
// Reset (rst_n, synchronous, active low) clears control state and restores the
// register defaults (tolerances 0.02 m and 0.01 rad, the rest zero).
// Top level of the fine-position PD controller; depends on fppd_pkg.
module fine_position_pd_controller
  import fppd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [119:0] in_tdata,    // pos_x[31:0], pos_y[63:32], heading[82:64],
                                    // timestamp_us[114:83], zero pad
  input  logic [1:0]   in_tuser,    // req_type[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,   // lin_cmd[31:0], ang_cmd[63:32]
  output logic [0:0]   out_tuser,   // achieved[0]
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  // configuration registers
  logic signed [31:0] tgt_dist_r, max_lin_r, max_ang_r;
  logic signed [21:0] tgt_ang_r;
  logic [30:0]        dist_tol_r;
  logic [20:0]        ang_tol_r;

  // controller state
  logic               running_r, first_r;
  logic signed [31:0] latest_x_r, latest_y_r, org_x_r, org_y_r, prev_x_r, prev_y_r;
  logic signed [21:0] latest_h_r, org_h_r, prev_h_r;
  logic [31:0]        prev_t_r;

  // current word
  logic signed [31:0] x_r, y_r;
  logic signed [18:0] h_r;
  logic [31:0]        t_r;

  // sequencer and datapath
  state_t             state_r, state_nxt;
  logic               sel_prev_r, arr_r, lin_en_r, mode_div_r, div_ang_r, neg_r;
  logic [63:0]        sx2_r;
  logic [32:0]        dcur_r, dprev_r;
  logic signed [21:0] hu_r;
  logic [31:0]        dt_r;
  logic signed [36:0] plin_r;
  logic signed [51:0] dlin_r, dang_r;
  logic [5:0]         cnt_r;
  logic [36:0]        rem_r;
  logic [65:0]        src_r;
  logic [50:0]        q_r;
  logic signed [35:0] mul_a_r;
  logic signed [32:0] mul_b_r;
  logic signed [68:0] prod_r;
  logic               out_valid_r;
  logic [63:0]        out_data_r;
  logic               out_ach_r;

  logic in_acc, cfg_wr, fin_load;
  assign in_acc   = in_tvalid && in_tready;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign fin_load = (state_r == S_FIN) && (!out_valid_r || out_tready);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ach_r;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr[4:2])
      REG_TGT_DIST: cfg_prdata = tgt_dist_r;
      REG_TGT_ANG:  cfg_prdata = 32'(tgt_ang_r);
      REG_MAX_LIN:  cfg_prdata = max_lin_r;
      REG_MAX_ANG:  cfg_prdata = max_ang_r;
      REG_DIST_TOL: cfg_prdata = {1'b0, dist_tol_r};
      REG_ANG_TOL:  cfg_prdata = {11'b0, ang_tol_r};
      default:      cfg_prdata = 32'b0;
    endcase
  end

  // unpack the input word
  logic signed [31:0] in_x, in_y;
  logic signed [18:0] in_h;
  assign in_x = in_tdata[31:0];
  assign in_y = in_tdata[63:32];
  assign in_h = in_tdata[82:64];

  // absolute coordinate difference to the origin, for the squaring pass
  logic signed [31:0] px, py;
  logic signed [32:0] dxs, dys;
  logic [32:0]        mxa, mya;
  assign px  = sel_prev_r ? prev_x_r : x_r;
  assign py  = sel_prev_r ? prev_y_r : y_r;
  assign dxs = 33'(px) - 33'(org_x_r);
  assign dys = 33'(py) - 33'(org_y_r);
  assign mxa = dxs[32] ? 33'(-dxs) : 33'(dxs);
  assign mya = dys[32] ? 33'(-dys) : 33'(dys);

  // signed distances, negated for a backward goal
  logic signed [33:0] sdcur, sdprev;
  assign sdcur  = tgt_dist_r[31] ? -$signed({1'b0, dcur_r})  : $signed({1'b0, dcur_r});
  assign sdprev = tgt_dist_r[31] ? -$signed({1'b0, dprev_r}) : $signed({1'b0, dprev_r});

  // arrival test: distance error, then heading modulo 2*pi
  logic signed [34:0] e_d;
  logic [34:0]        e_mag;
  logic signed [25:0] a0, ap, am;
  logic [25:0]        a0m, apm, amm;
  logic               dist_in, ang_in, arrive;
  always_comb begin
    e_d     = 35'(sdcur) - 35'(tgt_dist_r);
    e_mag   = e_d[34] ? 35'(-e_d) : 35'(e_d);
    a0      = 26'(tgt_ang_r) - (26'(h_r) - 26'(org_h_r));
    ap      = a0 + TWO_PI_Q;
    am      = a0 - TWO_PI_Q;
    a0m     = a0[25] ? 26'(-a0) : 26'(a0);
    apm     = ap[25] ? 26'(-ap) : 26'(ap);
    amm     = am[25] ? 26'(-am) : 26'(am);
    dist_in = (e_mag <= 35'(dist_tol_r));
    ang_in  = (a0m <= 26'(ang_tol_r)) || (apm <= 26'(ang_tol_r)) ||
              (amm <= 26'(ang_tol_r));
    if (!dist_in) begin
      // outside the band only an overshoot counts
      if (tgt_dist_r > 0)      arrive = !e_d[34] && (e_d != 0);
      else if (tgt_dist_r < 0) arrive = e_d[34];
      else                     arrive = 1'b0;
    end else begin
      arrive = ang_in;
    end
  end

  // heading unwrap against the previous heading
  logic signed [22:0] dh;
  logic signed [25:0] hv;
  always_comb begin
    dh = 23'(h_r) - 23'(prev_h_r);
    if (26'(dh) < -PI_Q)     hv = 26'(h_r) + TWO_PI_Q;
    else if (26'(dh) > PI_Q) hv = 26'(h_r) - TWO_PI_Q;
    else                     hv = 26'(h_r);
  end

  logic [32:0] td_mag;
  assign td_mag = tgt_dist_r[31] ? 33'(-33'(tgt_dist_r)) : 33'(tgt_dist_r);

  // proportional term of the distance law, truncated toward zero
  logic signed [52:0] p53, padj;
  assign p53  = prod_r[52:0];
  assign padj = p53 + $signed({37'b0, {16{p53[52]}}});

  // PD numerator magnitude for the divider
  logic [68:0] pmag;
  assign pmag = prod_r[68] ? 69'(-prod_r) : 69'(prod_r);

  // shared restoring step: square root (two bits) or division (one bit)
  logic [36:0] rs, tr;
  logic [37:0] diff;
  assign rs   = mode_div_r ? {rem_r[35:0], src_r[65]} : {rem_r[34:0], src_r[65:64]};
  assign tr   = mode_div_r ? {5'b0, dt_r} : {2'b0, q_r[32:0], 2'b01};
  assign diff = {1'b0, rs} - {1'b0, tr};

  logic signed [51:0] qsig;
  assign qsig = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

  // final command sums
  logic signed [23:0] err_ang;
  logic signed [52:0] lin_sum, ang_sum;
  always_comb begin
    err_ang = 24'(tgt_ang_r) - (24'(hu_r) - 24'(org_h_r));
    lin_sum = lin_en_r ? (53'(plin_r) + 53'(dlin_r)) : 53'sd0;
    ang_sum = 53'(err_ang) * 53'sd2 + 53'(dang_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_acc && in_tuser == REQ_SAMPLE && running_r) state_nxt = S_SQX;
      S_SQX:    state_nxt = S_SQX_W;
      S_SQX_W:  state_nxt = S_SQY;
      S_SQY:    state_nxt = S_SQY_W;
      S_SQY_W:  state_nxt = S_SUM;
      S_SUM:    state_nxt = S_ITER;
      S_ITER:   if (cnt_r == 6'd1) state_nxt = S_ITDONE;
      S_ITDONE: begin
        if (mode_div_r)      state_nxt = S_DIVEND;
        else if (sel_prev_r) state_nxt = S_PREP;
        else                 state_nxt = S_ARR;
      end
      S_ARR: begin
        if (arrive)       state_nxt = S_FIN;
        else if (first_r) state_nxt = S_PREP;
        else              state_nxt = S_SQX;
      end
      S_PREP:   state_nxt = S_LP;
      S_LP:     state_nxt = S_LP_W;
      S_LP_W:   state_nxt = S_LD;
      S_LD:     state_nxt = S_LD_W;
      S_LD_W:   state_nxt = S_LDIV;
      S_LDIV:   state_nxt = (dt_r == 32'd0) ? S_AD : S_ITER;
      S_DIVEND: state_nxt = div_ang_r ? S_FIN : S_AD;
      S_AD:     state_nxt = S_AD_W;
      S_AD_W:   state_nxt = S_ADIV;
      S_ADIV:   state_nxt = (dt_r == 32'd0) ? S_FIN : S_ITER;
      S_FIN:    if (fin_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // multiplier: registered product of the operand registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a_r * mul_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      running_r   <= 1'b0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
      tgt_dist_r  <= '0;
      tgt_ang_r   <= '0;
      max_lin_r   <= '0;
      max_ang_r   <= '0;
      dist_tol_r  <= 31'd1311;
      ang_tol_r   <= 21'd655;
      latest_x_r  <= '0;
      latest_y_r  <= '0;
      latest_h_r  <= '0;
      org_x_r     <= '0;
      org_y_r     <= '0;
      org_h_r     <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_h_r    <= '0;
      prev_t_r    <= '0;
      cnt_r       <= '0;
      mode_div_r  <= 1'b0;
      sel_prev_r  <= 1'b0;
      arr_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready && !fin_load) out_valid_r <= 1'b0;

      if (cfg_wr) begin
        case (cfg_paddr[4:2])
          REG_TGT_DIST: tgt_dist_r <= cfg_pwdata;
          REG_TGT_ANG:  tgt_ang_r  <= cfg_pwdata[21:0];
          REG_MAX_LIN:  max_lin_r  <= cfg_pwdata;
          REG_MAX_ANG:  max_ang_r  <= cfg_pwdata;
          REG_DIST_TOL: dist_tol_r <= cfg_pwdata[30:0];
          REG_ANG_TOL:  ang_tol_r  <= cfg_pwdata[20:0];
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_tuser)
              REQ_SAMPLE: begin
                // odometry sample: always track the latest pose
                latest_x_r <= in_x;
                latest_y_r <= in_y;
                latest_h_r <= 22'(in_h);
                x_r        <= in_x;
                y_r        <= in_y;
                h_r        <= in_h;
                t_r        <= in_tdata[114:83];
                sel_prev_r <= 1'b0;
                arr_r      <= 1'b0;
              end
              REQ_START: begin
                org_x_r   <= latest_x_r;
                org_y_r   <= latest_y_r;
                org_h_r   <= latest_h_r;
                running_r <= 1'b1;
              end
              REQ_STOP: running_r <= 1'b0;
              default: ;
            endcase
          end
        end
        S_SQX: begin
          mul_a_r <= {4'b0, mxa[31:0]};
          mul_b_r <= {1'b0, mxa[31:0]};
        end
        S_SQY: begin
          sx2_r   <= prod_r[63:0];
          mul_a_r <= {4'b0, mya[31:0]};
          mul_b_r <= {1'b0, mya[31:0]};
        end
        S_SUM: begin
          // load the root pass with dx^2 + dy^2
          src_r      <= {1'b0, 65'(sx2_r) + 65'(prod_r[63:0])};
          rem_r      <= '0;
          q_r        <= '0;
          cnt_r      <= 6'(SQRT_STEPS);
          mode_div_r <= 1'b0;
        end
        S_ITER: begin
          if (!diff[37]) begin
            rem_r <= diff[36:0];
            q_r   <= {q_r[49:0], 1'b1};
          end else begin
            rem_r <= rs;
            q_r   <= {q_r[49:0], 1'b0};
          end
          src_r <= mode_div_r ? {src_r[64:0], 1'b0} : {src_r[63:0], 2'b00};
          cnt_r <= cnt_r - 6'd1;
        end
        S_ITDONE: begin
          if (!mode_div_r) begin
            if (sel_prev_r) dprev_r <= q_r[32:0];
            else            dcur_r  <= q_r[32:0];
          end
        end
        S_ARR: begin
          if (arrive) begin
            arr_r <= 1'b1;
          end else if (first_r) begin
            // first sample: origin and previous pose take this sample
            org_x_r  <= x_r;
            org_y_r  <= y_r;
            org_h_r  <= 22'(h_r);
            prev_x_r <= x_r;
            prev_y_r <= y_r;
            prev_h_r <= 22'(h_r);
            prev_t_r <= t_r;
            first_r  <= 1'b0;
            dcur_r   <= '0;
            dprev_r  <= '0;
          end else begin
            sel_prev_r <= 1'b1;
          end
        end
        S_PREP: begin
          hu_r     <= hv[21:0];
          dt_r     <= t_r - prev_t_r;
          lin_en_r <= (td_mag > 33'(dist_tol_r));
        end
        S_LP: begin
          mul_a_r <= 36'(35'(tgt_dist_r) - 35'(sdcur));
          mul_b_r <= KP_LIN;
        end
        S_LD: begin
          plin_r  <= padj[52:16];
          mul_a_r <= 36'(sdprev) - 36'(sdcur);
          mul_b_r <= KD_LIN;
        end
        S_LDIV: begin
          dlin_r     <= '0;
          neg_r      <= prod_r[68];
          src_r      <= {pmag[50:0], 15'b0};
          rem_r      <= '0;
          q_r        <= '0;
          cnt_r      <= 6'(DIV_STEPS);
          mode_div_r <= 1'b1;
          div_ang_r  <= 1'b0;
        end
        S_DIVEND: begin
          if (div_ang_r) dang_r <= qsig;
          else           dlin_r <= qsig;
        end
        S_AD: begin
          mul_a_r <= 36'(prev_h_r) - 36'(hu_r);
          mul_b_r <= KD_ANG;
        end
        S_ADIV: begin
          dang_r     <= '0;
          neg_r      <= prod_r[68];
          src_r      <= {pmag[50:0], 15'b0};
          rem_r      <= '0;
          q_r        <= '0;
          cnt_r      <= 6'(DIV_STEPS);
          mode_div_r <= 1'b1;
          div_ang_r  <= 1'b1;
        end
        S_FIN: begin
          if (fin_load) begin
            out_valid_r <= 1'b1;
            if (arr_r) begin
              // arrival: zero commands, drop the goal and stop
              out_data_r <= '0;
              out_ach_r  <= 1'b1;
              tgt_dist_r <= '0;
              tgt_ang_r  <= '0;
              running_r  <= 1'b0;
              first_r    <= 1'b1;
            end else begin
              out_data_r <= {sat_cap(ang_sum, max_ang_r), sat_cap(lin_sum, max_lin_r)};
              out_ach_r  <= 1'b0;
              prev_x_r   <= x_r;
              prev_y_r   <= y_r;
              prev_h_r   <= hu_r;
              prev_t_r   <= t_r;
              latest_h_r <= hu_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ach_r |-> out_data_r == 64'b0)
    else $error("achieved word carries nonzero commands");

  a_arr_stop: assert property (@(posedge clk) disable iff (!rst_n)
    fin_load && arr_r |=> !running_r && first_r && tgt_dist_r == 32'sd0)
    else $error("arrival did not stop the controller");

  a_iter_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ITER |-> cnt_r != 6'd0 && cnt_r <= 6'(DIV_STEPS))
    else $error("iteration count out of range");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser == REQ_SAMPLE && running_r |=> state_r == S_SQX)
    else $error("running sample did not start the distance pass");
`endif

endmodule
